FILE: hdl/imc_pkg.sv
package imc_pkg;

   // Width of one stored entry: start in the upper half, end in the lower half.
   localparam int unsigned EntryWidth = 64;
   localparam int unsigned HalfWidth  = 32;
   localparam int unsigned CountWidth = 11;

   // Inverting the sign bit makes unsigned order match signed order.
   localparam logic [HalfWidth-1:0] SignFlip = 32'h8000_0000;

   typedef enum logic [3:0] {
      S_LOAD,
      S_PASS,
      S_RUN,
      S_RD,
      S_MRG,
      S_SW_RD,
      S_SW_A,
      S_SW_B,
      S_OUT
   } state_type;

endpackage

FILE: hdl/imc_if.sv
interface imc_req_if
   import imc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [HalfWidth-1:0] interval_start;
   logic [HalfWidth-1:0] interval_end;
   logic                 last_item;
   modport source (output valid, interval_start, interval_end, last_item, input ready);
   modport sink   (input valid, interval_start, interval_end, last_item, output ready);
endinterface

interface imc_rsp_if
   import imc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CountWidth-1:0] merged_count;
   logic                  overflow;
   modport source (output valid, merged_count, overflow, input ready);
   modport sink   (input valid, merged_count, overflow, output ready);
endinterface

FILE: hdl/imc_cmp.sv
module imc_cmp
   import imc_pkg::*;
(
   input  logic [EntryWidth-1:0] lhs,
   input  logic [EntryWidth-1:0] rhs,
   output logic                  lt
);

   // Shared unsigned less-than used by both the sort and the sweep.
   assign lt = (lhs < rhs);

endmodule

FILE: hdl/interval_merge_count.sv
// Channel   Direction  Payload
// req_chan  in         interval_start, interval_end, last_item
// rsp_chan  out        merged_count, overflow
//
// Loading accepts one item per cycle. After the last item the block sorts the
// store by bottom-up merge passes, each moved entry being read and then merged,
// then sweeps it, reading each entry, testing its start and, where it overlaps, its end, all
// through one comparator. Reset is synchronous and clears the sequencer and
// counters only. The block takes no item from the last one until its result is taken.
module interval_merge_count
   import imc_pkg::*;
#(
   parameter int unsigned MAX_INTERVALS = 1024
)
(
   input  logic          clock,
   input  logic          reset,
   imc_req_if.sink       req_chan,
   imc_rsp_if.source     rsp_chan
);

   localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
   localparam int unsigned AW = $clog2(MAX_INTERVALS);
   localparam int unsigned WW = CW + 2;
   localparam logic [WW-1:0] MaxCount = WW'(MAX_INTERVALS);

   // Two banks: the store and the merge scratch, swapped after each pass.
   logic [EntryWidth-1:0] bank0 [MAX_INTERVALS];
   logic [EntryWidth-1:0] bank1 [MAX_INTERVALS];

   state_type state_ff, state_in;
   logic [WW-1:0] cnt_ff, cnt_in, wid_ff, wid_in, lo_ff, lo_in;
   logic [WW-1:0] mid_ff, mid_in, hi_ff, hi_in;
   logic [WW-1:0] a_ff, a_in, b_ff, b_in, k_ff, k_in;
   logic          src_ff, src_in, ovf_ff, ovf_in, have_ff, have_in;
   logic [HalfWidth-1:0] cur_end_ff, cur_end_in;
   logic [CW-1:0] tally_ff, tally_in;
   logic [EntryWidth-1:0] rd_a_ff, rd_b_ff;
   logic          rd_en;
   logic [WW-1:0] rd_a_addr, rd_b_addr;
   logic          wr_en, wr_bank;
   logic [WW-1:0] wr_addr;
   logic [EntryWidth-1:0] wr_data;
   logic [EntryWidth-1:0] cmp_lhs, cmp_rhs;
   logic          cmp_lt;
   logic [WW-1:0] sum_mid, sum_hi;
   logic          req_acc;

   imc_cmp u_cmp (.lhs(cmp_lhs), .rhs(cmp_rhs), .lt(cmp_lt));

   assign req_acc = req_chan.valid & req_chan.ready;
   assign sum_mid = lo_ff + wid_ff;
   assign sum_hi  = sum_mid + wid_ff;

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         have_ff  <= 1'b0;
         tally_ff <= '0;
         src_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         have_ff  <= have_in;
         tally_ff <= tally_in;
         src_ff   <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      wid_ff     <= wid_in;
      lo_ff      <= lo_in;
      mid_ff     <= mid_in;
      hi_ff      <= hi_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      cur_end_ff <= cur_end_in;
   end

   // Memory write port and registered reads from the current source bank.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_bank) begin
            bank1[wr_addr[AW-1:0]] <= wr_data;
         end else begin
            bank0[wr_addr[AW-1:0]] <= wr_data;
         end
      end
      if (rd_en) begin
         if (src_ff) begin
            rd_a_ff <= bank1[rd_a_addr[AW-1:0]];
            rd_b_ff <= bank1[rd_b_addr[AW-1:0]];
         end else begin
            rd_a_ff <= bank0[rd_a_addr[AW-1:0]];
            rd_b_ff <= bank0[rd_b_addr[AW-1:0]];
         end
      end
   end

   // Sequencer: load, merge passes, sweep, result.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      have_in    = have_ff;
      tally_in   = tally_ff;
      src_in     = src_ff;
      wid_in     = wid_ff;
      lo_in      = lo_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      cur_end_in = cur_end_ff;
      rd_en      = 1'b0;
      rd_a_addr  = a_ff;
      rd_b_addr  = b_ff;
      wr_en      = 1'b0;
      wr_bank    = ~src_ff;
      wr_addr    = k_ff;
      wr_data    = rd_a_ff;
      cmp_lhs    = rd_b_ff;
      cmp_rhs    = rd_a_ff;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_chan.ready = 1'b1;
            wr_bank = 1'b0;
            wr_addr = cnt_ff;
            wr_data = {req_chan.interval_start ^ SignFlip,
                       req_chan.interval_end ^ SignFlip};
            if (req_acc) begin
               if (cnt_ff < MaxCount) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last_item) begin
                  wid_in   = WW'(1);
                  state_in = S_PASS;
               end
            end
         end
         S_PASS: begin
            lo_in = '0;
            if (wid_ff < cnt_ff) begin
               state_in = S_RUN;
            end else begin
               a_in     = '0;
               have_in  = 1'b0;
               tally_in = '0;
               state_in = S_SW_RD;
            end
         end
         S_RUN: begin
            // Set up the next pair of runs, or end the pass.
            if (lo_ff >= cnt_ff) begin
               wid_in   = {wid_ff[WW-2:0], 1'b0};
               src_in   = ~src_ff;
               state_in = S_PASS;
            end else begin
               mid_in   = (sum_mid < cnt_ff) ? sum_mid : cnt_ff;
               hi_in    = (sum_hi < cnt_ff) ? sum_hi : cnt_ff;
               a_in     = lo_ff;
               b_in     = (sum_mid < cnt_ff) ? sum_mid : cnt_ff;
               k_in     = lo_ff;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if ((a_ff < mid_ff) || (b_ff < hi_ff)) begin
               rd_en    = 1'b1;
               state_in = S_MRG;
            end else begin
               lo_in    = sum_hi;
               state_in = S_RUN;
            end
         end
         S_MRG: begin
            // Take the right run's head when it is strictly smaller or the left run is used up.
            wr_en = 1'b1;
            k_in  = k_ff + 1'b1;
            if ((a_ff < mid_ff) && !((b_ff < hi_ff) && cmp_lt)) begin
               wr_data = rd_a_ff;
               a_in    = a_ff + 1'b1;
            end else begin
               wr_data = rd_b_ff;
               b_in    = b_ff + 1'b1;
            end
            state_in = S_RD;
         end
         S_SW_RD: begin
            if (a_ff < cnt_ff) begin
               rd_en    = 1'b1;
               state_in = S_SW_A;
            end else begin
               tally_in = tally_ff + CW'(have_ff);
               state_in = S_OUT;
            end
         end
         S_SW_A: begin
            // Does this interval start beyond the current merged end?
            cmp_lhs = {{HalfWidth{1'b0}}, cur_end_ff};
            cmp_rhs = {{HalfWidth{1'b0}}, rd_a_ff[EntryWidth-1:HalfWidth]};
            if (!have_ff || cmp_lt) begin
               tally_in   = tally_ff + CW'(have_ff);
               cur_end_in = rd_a_ff[HalfWidth-1:0];
               have_in    = 1'b1;
               a_in       = a_ff + 1'b1;
               state_in   = S_SW_RD;
            end else begin
               state_in = S_SW_B;
            end
         end
         S_SW_B: begin
            // Extend the merged end if this interval reaches further.
            cmp_lhs = {{HalfWidth{1'b0}}, cur_end_ff};
            cmp_rhs = {{HalfWidth{1'b0}}, rd_a_ff[HalfWidth-1:0]};
            if (cmp_lt) begin
               cur_end_in = rd_a_ff[HalfWidth-1:0];
            end
            a_in     = a_ff + 1'b1;
            state_in = S_SW_RD;
         end
         S_OUT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               have_in  = 1'b0;
               tally_in = '0;
               src_in   = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   assign rsp_chan.merged_count = CountWidth'(tally_ff);
   assign rsp_chan.overflow     = ovf_ff;

   // A result never waits while a new item is being taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("result and input both open");

   // Once a result is taken the block is back to loading.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready) |=> (req_chan.ready && cnt_ff == '0))
      else $error("block did not return to loading");

   // An item arriving at a full store sets the overflow flag.
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && cnt_ff == MaxCount) |=> ovf_ff)
      else $error("dropped item not flagged");

endmodule
